// File: rtl/lpcd_pkg.sv
// types and constants shared by the length-prefixed channel deframer
// no dependencies; compile first

package lpcd_pkg;

	// framing format
	localparam int unsigned FRAME_LEN_BITS = 32;
	localparam int unsigned ID_BYTES       = 4;
	localparam int unsigned CTRL_BYTES     = 6;
	localparam int unsigned POS_BITS       = 3;

	// channel codes
	localparam logic [7:0] CH_CONTROL = 8'd0;
	localparam logic [7:0] CH_USER    = 8'd1;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_BITS = 2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_CLIENT_SIDE = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PEER_TAG    = 2'd1;

	typedef enum logic [2:0] {
		PH_LEN0,
		PH_LEN1,
		PH_LEN2,
		PH_LEN3,
		PH_CHAN,
		PH_BODY,
		PH_STOP
	} phase_t;

	typedef enum logic [1:0] {
		EV_DATA  = 2'd0,
		EV_EMPTY = 2'd1,
		EV_CTRL  = 2'd2,
		EV_BAD   = 2'd3
	} event_kind_t;

	// result produced by the parser for one byte
	typedef struct packed {
		logic        valid;
		event_kind_t kind;
		logic [7:0]  data_byte;
		logic        last;
		logic [31:0] id;
		logic [15:0] port;
	} emit_t;

endpackage

// File: rtl/lpcd_if.sv
// stream channels of the deframer: input bytes and result events
// depends on lpcd_pkg

interface lpcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink   (input valid, input stream_byte, output ready);
endinterface

interface lpcd_event_if;
	logic                      valid;
	logic                      ready;
	lpcd_pkg::event_kind_t     event_kind;
	logic [7:0]                data_byte;
	logic                      last_of_message;
	logic [31:0]               assigned_id;
	logic [15:0]               udp_port;
	logic [31:0]               source_peer;

	modport source (output valid, output event_kind, output data_byte,
		output last_of_message, output assigned_id, output udp_port,
		output source_peer, input ready);
	modport sink   (input valid, input event_kind, input data_byte,
		input last_of_message, input assigned_id, input udp_port,
		input source_peer, output ready);
endinterface

// File: rtl/length_prefixed_channel_deframer.sv
// top level of the length-prefixed channel deframer
// depends on lpcd_pkg, lpcd_if, lpcd_parser, lpcd_out_reg
//
// Usage: in_ch carries one stream byte per transfer; out_ch carries at most
// one event per byte (user payload byte, empty user message, control info
// with id and port, or bad length). Each frame is a 4-byte little-endian
// length, a channel byte and length-1 payload bytes.
// Path: a byte taken from in_ch is held in the input register, parsed from
// there once the result slot is free, and its event enters the result
// register, which drives out_ch.
// Throughput: one byte per cycle while out_ch stays ready, set by the single
// pass from the input register through the parser to the result register.
// Stall: while out_ch is not ready, one more byte waits in the input
// register and in_ch.ready drops; nothing is lost.
// Reset (arst_n low): parser returns to the first length byte, the halt is
// cleared, configuration registers go to zero, no event is pending.
// A bad length (zero, or above the LENGTH_BITS range) gives one event, then
// all further bytes are taken and dropped until reset.
// Configuration: write client_side (index 0) and peer_tag (index 1) while
// no byte is in flight.

module length_prefixed_channel_deframer #(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lpcd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [31:0]                         cfg_wdata,
	lpcd_byte_if.sink                           in_ch,
	lpcd_event_if.source                        out_ch
);

	logic            client_side_q;
	logic [31:0]     peer_tag_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            slot_free;
	logic            advance;
	lpcd_pkg::emit_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			client_side_q <= 1'b0;
			peer_tag_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lpcd_pkg::REG_CLIENT_SIDE: client_side_q <= cfg_wdata[0];
				lpcd_pkg::REG_PEER_TAG:    peer_tag_q    <= cfg_wdata;
				default:                   ;
			endcase
		end
	end

	assign advance     = valid_s1 && slot_free;
	assign in_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			byte_s1 <= in_ch.stream_byte;
	end

	lpcd_parser #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.stream_byte (byte_s1),
		.client_side (client_side_q),
		.res         (res)
	);

	lpcd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && res.valid),
		.res       (res),
		.peer_tag  (peer_tag_q),
		.slot_free (slot_free),
		.out_ch    (out_ch)
	);

	// an empty input register always takes a byte
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ch.ready)
		else $error("input stalled with empty input register");

	// an emitted result shows up on the event channel
	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.valid |=> out_ch.valid)
		else $error("emitted result not presented");

	// a byte is only processed while the result slot can take its event
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> slot_free && valid_s1)
		else $error("byte processed while result slot busy");

endmodule

// File: rtl/lpcd_parser.sv
// frame parser: phase machine, length assembly, control capture
// depends on lpcd_pkg

module lpcd_parser #(
	parameter int unsigned LENGTH_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  logic [7:0]      stream_byte,
	input  logic            client_side,
	output lpcd_pkg::emit_t res
);

	lpcd_pkg::phase_t                     phase_q, phase_d;
	logic [lpcd_pkg::FRAME_LEN_BITS-1:0]  len_q, len_d;
	logic [lpcd_pkg::FRAME_LEN_BITS-1:0]  full_len;
	logic [LENGTH_BITS-1:0]               left_q, left_d;
	logic [7:0]                           chan_q, chan_d;
	logic [lpcd_pkg::POS_BITS-1:0]        pos_q, pos_d;
	logic [31:0]                          id_q, id_d;
	logic [15:0]                          port_q, port_d;
	logic                                 last_byte;

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpcd_pkg::PH_LEN0;
			len_q   <= '0;
			left_q  <= '0;
			chan_q  <= '0;
			pos_q   <= '0;
			id_q    <= '0;
			port_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			left_q  <= left_d;
			chan_q  <= chan_d;
			pos_q   <= pos_d;
			id_q    <= id_d;
			port_q  <= port_d;
		end
	end

	assign full_len  = {stream_byte, len_q[23:0]};
	assign last_byte = (left_q == LENGTH_BITS'(1));

	function automatic logic [lpcd_pkg::POS_BITS-1:0] POS_BITS_MAX();
		return lpcd_pkg::POS_BITS'(lpcd_pkg::CTRL_BYTES);
	endfunction

	// next state and result for the byte at hand
	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		left_d  = left_q;
		chan_d  = chan_q;
		pos_d   = pos_q;
		id_d    = id_q;
		port_d  = port_q;
		res     = '0;
		case (phase_q)
			lpcd_pkg::PH_LEN0: begin
				len_d   = {24'd0, stream_byte};
				phase_d = lpcd_pkg::PH_LEN1;
			end
			lpcd_pkg::PH_LEN1: begin
				len_d[15:8] = stream_byte;
				phase_d     = lpcd_pkg::PH_LEN2;
			end
			lpcd_pkg::PH_LEN2: begin
				len_d[23:16] = stream_byte;
				phase_d      = lpcd_pkg::PH_LEN3;
			end
			lpcd_pkg::PH_LEN3: begin
				len_d = full_len;
				// zero or too wide for the length field: report and halt
				if (full_len == '0 || (full_len >> LENGTH_BITS) != '0) begin
					phase_d   = lpcd_pkg::PH_STOP;
					res.valid = 1'b1;
					res.kind  = lpcd_pkg::EV_BAD;
				end else begin
					phase_d = lpcd_pkg::PH_CHAN;
				end
			end
			lpcd_pkg::PH_CHAN: begin
				chan_d = stream_byte;
				left_d = len_q[LENGTH_BITS-1:0] - LENGTH_BITS'(1);
				pos_d  = '0;
				if (left_d == '0) begin
					phase_d = lpcd_pkg::PH_LEN0;
					if (stream_byte == lpcd_pkg::CH_USER) begin
						res.valid = 1'b1;
						res.kind  = lpcd_pkg::EV_EMPTY;
					end
				end else begin
					phase_d = lpcd_pkg::PH_BODY;
				end
			end
			lpcd_pkg::PH_BODY: begin
				left_d = left_q - LENGTH_BITS'(1);
				if (last_byte)
					phase_d = lpcd_pkg::PH_LEN0;
				// saturating payload position, only the first six matter
				if (pos_q != POS_BITS_MAX())
					pos_d = pos_q + lpcd_pkg::POS_BITS'(1);
				if (chan_q == lpcd_pkg::CH_USER) begin
					res.valid     = 1'b1;
					res.kind      = lpcd_pkg::EV_DATA;
					res.data_byte = stream_byte;
					res.last      = last_byte;
				end else if (chan_q == lpcd_pkg::CH_CONTROL) begin
					if (pos_q < lpcd_pkg::POS_BITS'(lpcd_pkg::ID_BYTES))
						id_d[8*pos_q[1:0] +: 8] = stream_byte;
					else if (pos_q < lpcd_pkg::POS_BITS'(lpcd_pkg::CTRL_BYTES))
						port_d[8*pos_q[0] +: 8] = stream_byte;
					// at least six payload bytes means this one is at position five or later
					if (last_byte && client_side &&
						pos_q >= lpcd_pkg::POS_BITS'(lpcd_pkg::CTRL_BYTES - 1)) begin
						res.valid = 1'b1;
						res.kind  = lpcd_pkg::EV_CTRL;
						res.id    = id_d;
						res.port  = port_d;
					end
				end
			end
			lpcd_pkg::PH_STOP: begin
				phase_d = lpcd_pkg::PH_STOP;
			end
			default: begin
				phase_d = lpcd_pkg::PH_STOP;
			end
		endcase
	end

	// halted parser stays silent
	a_stop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lpcd_pkg::PH_STOP |-> !res.valid)
		else $error("result produced after halt");

	// bad length is only ever reported on the last length byte
	a_bad_at_len3: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == lpcd_pkg::EV_BAD |-> phase_q == lpcd_pkg::PH_LEN3)
		else $error("bad length reported outside length assembly");

	// a payload phase always has bytes left to take
	a_body_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == lpcd_pkg::PH_BODY |-> left_q != '0)
		else $error("payload phase with no bytes left");

endmodule

// File: rtl/lpcd_out_reg.sv
// result register driving the event channel
// depends on lpcd_pkg and lpcd_if

module lpcd_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  lpcd_pkg::emit_t     res,
	input  logic [31:0]         peer_tag,
	output logic                slot_free,
	lpcd_event_if.source        out_ch
);

	logic                  valid_q;
	lpcd_pkg::event_kind_t kind_q;
	logic [7:0]            data_q;
	logic                  last_q;
	logic [31:0]           id_q;
	logic [15:0]           port_q;
	logic [31:0]           peer_q;

	// valid flag: set on load, cleared when the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (out_ch.ready)
			valid_q <= 1'b0;
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= res.kind;
			data_q <= res.data_byte;
			last_q <= res.last;
			id_q   <= res.id;
			port_q <= res.port;
			peer_q <= peer_tag;
		end
	end

	assign slot_free              = !valid_q || out_ch.ready;
	assign out_ch.valid           = valid_q;
	assign out_ch.event_kind      = kind_q;
	assign out_ch.data_byte       = data_q;
	assign out_ch.last_of_message = last_q;
	assign out_ch.assigned_id     = id_q;
	assign out_ch.udp_port        = port_q;
	assign out_ch.source_peer     = peer_q;

endmodule
